>>> hw/rtl/ppp_pkg.sv
// Package for the parallel printer port: command and result codes,
// register indexes and byte constants. No dependencies.
package ppp_pkg;

  typedef enum logic [2:0] {
    CMD_RD_DATA  = 3'd0,
    CMD_RD_CTRL  = 3'd1,
    CMD_RD_STAT  = 3'd2,
    CMD_WR_DATA  = 3'd3,
    CMD_WR_CTRL  = 3'd4,
    CMD_TICK     = 3'd5,
    CMD_RSVD6    = 3'd6,
    CMD_RSVD7    = 3'd7
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_READ  = 2'd0,
    KIND_PRINT = 2'd1,
    KIND_CLOSE = 2'd2,
    KIND_RSVD  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_ADD_LF  = 2'd0,
    REG_ADD_FF  = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  localparam logic [7:0]  STATUS_BASE  = 8'h9F;
  localparam logic [7:0]  STATUS_NOACK = 8'h40;
  localparam logic [7:0]  CHAR_CR      = 8'h0D;
  localparam logic [7:0]  CHAR_LF      = 8'h0A;
  localparam logic [7:0]  CHAR_FF      = 8'd12;
  localparam logic [3:0]  CTRL_MASK    = 4'hF;
  localparam int unsigned CTRL_STROBE  = 0;
  localparam int unsigned CTRL_AUTOLF  = 1;
  localparam logic [15:0] TIMEOUT_RST  = 16'd500;
  localparam logic [16:0] IDLE_MAX     = 17'h1FFFF;
  localparam int unsigned RES_DEPTH    = 3;

endpackage

>>> hw/rtl/parallel_printer_port.sv
// Top level of the parallel printer port: input register, print/job logic,
// result bundle register and APB-style register port. Uses ppp_pkg.
//
// Usage: each item on the in_ channel is one bus access or one tick
// (in_tuser = command, in_tdata = byte for writes). The out_ channel returns
// the results of each item in order: out_tuser = kind (read, printed byte,
// job closed), out_tdata = byte, out_tlast marks the final result of an item.
// Items that cause no result (data writes, writes without a strobe edge,
// quiet ticks, unused commands) produce nothing on out_.
// An accepted item waits in the input register, then its results are loaded
// into the result register and shown on out_. Throughput: one item per
// cycle while no item has more than one result and out_tready is high.
// An item with several results (up to 3: a CR with both line-feed options;
// 2: a form feed plus job close) holds the result register until all are
// taken, one per cycle while out_tready is high, and it alone sets the rate.
// Reset (rst_n low, synchronous): all port state clears, no job is open,
// idle_timeout returns to 500 and both feed options are off.
// When the receiver stalls, the result register holds; one more item can
// wait in the input register, then in_tready drops.
// Registers at byte addresses 0 (add_line_feed), 4 (add_form_feed),
// 8 (idle_timeout); write them only while the port is idle.
module parallel_printer_port (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] write_value
  input  logic [2:0]  in_tuser,   // [2:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] value
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ppp_pkg::*;

  // configuration
  logic        add_lf_r;
  logic        add_ff_r;
  logic [15:0] timeout_r;
  reg_idx_t    cfg_idx;
  logic        cfg_wr;

  // input register
  logic        in_vld_r;
  cmd_t        in_cmd_r;
  logic [7:0]  in_wv_r;

  // port state
  logic [7:0]  data_latch_r, data_latch_nxt;
  logic [3:0]  ctrl_r, ctrl_nxt;
  logic        ack_r, ack_nxt;
  logic [7:0]  prev_r, prev_nxt;
  logic        job_r, job_nxt;
  logic [16:0] idle_r, idle_nxt;

  // result bundle
  kind_t       res_kind_r [RES_DEPTH];
  logic [7:0]  res_val_r  [RES_DEPTH];
  logic [1:0]  res_cnt_r;
  logic [1:0]  res_idx_r;
  kind_t       res_kind_nxt [RES_DEPTH];
  logic [7:0]  res_val_nxt  [RES_DEPTH];
  logic [1:0]  res_cnt_nxt;

  logic        take;
  logic        bundle_free;
  logic        move;
  logic        strobe_fall;
  logic [16:0] idle_inc;
  logic        close;

  // ---------------- configuration port ----------------
  assign cfg_pready = 1'b1;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[3:2]);
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    unique case (cfg_idx)
      REG_ADD_LF:  cfg_prdata = {31'd0, add_lf_r};
      REG_ADD_FF:  cfg_prdata = {31'd0, add_ff_r};
      REG_TIMEOUT: cfg_prdata = {16'd0, timeout_r};
      default:     cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_lf_r  <= 1'b0;
      add_ff_r  <= 1'b0;
      timeout_r <= TIMEOUT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ADD_LF:  add_lf_r  <= cfg_pwdata[0];
        REG_ADD_FF:  add_ff_r  <= cfg_pwdata[0];
        REG_TIMEOUT: timeout_r <= cfg_pwdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------- handshakes ----------------
  assign out_tvalid  = res_idx_r < res_cnt_r;
  assign out_tlast   = (res_idx_r + 2'd1) == res_cnt_r;
  assign out_tdata   = res_val_r[res_idx_r];
  assign out_tuser   = res_kind_r[res_idx_r];
  assign take        = out_tvalid & out_tready;
  assign bundle_free = !out_tvalid | (take & out_tlast);
  assign move        = in_vld_r & bundle_free;
  assign in_tready   = !in_vld_r | move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_cmd_r <= cmd_t'(in_tuser);
      in_wv_r  <= in_tdata;
    end
  end

  // ---------------- item processing ----------------
  assign strobe_fall = !in_wv_r[CTRL_STROBE] & ctrl_r[CTRL_STROBE];
  assign idle_inc    = (idle_r == IDLE_MAX) ? idle_r : idle_r + 17'd1;
  assign close       = (timeout_r != 16'd0) && (idle_inc > {1'b0, timeout_r});

  always_comb begin
    data_latch_nxt = data_latch_r;
    ctrl_nxt       = ctrl_r;
    ack_nxt        = ack_r;
    prev_nxt       = prev_r;
    job_nxt        = job_r;
    idle_nxt       = idle_r;
    res_cnt_nxt    = 2'd0;
    for (int i = 0; i < RES_DEPTH; i++) begin
      res_kind_nxt[i] = KIND_READ;
      res_val_nxt[i]  = 8'd0;
    end

    unique case (in_cmd_r)
      CMD_RD_DATA: begin
        res_val_nxt[0] = data_latch_r;
        res_cnt_nxt    = 2'd1;
      end
      CMD_RD_CTRL: begin
        res_val_nxt[0] = {4'd0, ctrl_r};
        res_cnt_nxt    = 2'd1;
      end
      CMD_RD_STAT: begin
        res_val_nxt[0] = STATUS_BASE | (ack_r ? 8'd0 : STATUS_NOACK);
        res_cnt_nxt    = 2'd1;
        ack_nxt        = 1'b0;
      end
      CMD_WR_DATA: begin
        data_latch_nxt = in_wv_r;
      end
      CMD_WR_CTRL: begin
        if (strobe_fall) begin
          job_nxt  = 1'b1;
          idle_nxt = 17'd0;
          ack_nxt  = 1'b1;
          res_kind_nxt[0] = KIND_PRINT;
          res_val_nxt[0]  = data_latch_r;
          res_cnt_nxt     = 2'd1;
          // with add_lf_r: extra LF after a printed CR unless this byte is LF
          if (add_lf_r && prev_r == CHAR_CR && data_latch_r != CHAR_LF) begin
            res_kind_nxt[res_cnt_nxt] = KIND_PRINT;
            res_val_nxt[res_cnt_nxt]  = CHAR_LF;
            res_cnt_nxt               = res_cnt_nxt + 2'd1;
          end
          if (add_lf_r) begin
            prev_nxt = data_latch_r;
          end
          // autofeed: LF after a printed CR
          if (in_wv_r[CTRL_AUTOLF] && data_latch_r == CHAR_CR) begin
            res_kind_nxt[res_cnt_nxt] = KIND_PRINT;
            res_val_nxt[res_cnt_nxt]  = CHAR_LF;
            res_cnt_nxt               = res_cnt_nxt + 2'd1;
            if (add_lf_r) begin
              prev_nxt = CHAR_LF;
            end
          end
        end
        ctrl_nxt = in_wv_r[3:0] & CTRL_MASK;
      end
      CMD_TICK: begin
        if (job_r) begin
          if (close) begin
            if (add_ff_r) begin
              res_kind_nxt[res_cnt_nxt] = KIND_PRINT;
              res_val_nxt[res_cnt_nxt]  = CHAR_FF;
              res_cnt_nxt               = res_cnt_nxt + 2'd1;
            end
            res_kind_nxt[res_cnt_nxt] = KIND_CLOSE;
            res_val_nxt[res_cnt_nxt]  = 8'd0;
            res_cnt_nxt               = res_cnt_nxt + 2'd1;
            prev_nxt = 8'd0;
            job_nxt  = 1'b0;
            idle_nxt = 17'd0;
          end else begin
            idle_nxt = idle_inc;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_latch_r <= 8'd0;
      ctrl_r       <= 4'd0;
      ack_r        <= 1'b0;
      prev_r       <= 8'd0;
      job_r        <= 1'b0;
      idle_r       <= 17'd0;
    end else if (move) begin
      data_latch_r <= data_latch_nxt;
      ctrl_r       <= ctrl_nxt;
      ack_r        <= ack_nxt;
      prev_r       <= prev_nxt;
      job_r        <= job_nxt;
      idle_r       <= idle_nxt;
    end
  end

  // result bundle: loaded whole; one result drained per cycle when not stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_cnt_r <= 2'd0;
      res_idx_r <= 2'd0;
    end else if (move) begin
      res_cnt_r <= res_cnt_nxt;
      res_idx_r <= 2'd0;
    end else if (take) begin
      res_idx_r <= res_idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      for (int i = 0; i < RES_DEPTH; i++) begin
        res_kind_r[i] <= res_kind_nxt[i];
        res_val_r[i]  <= res_val_nxt[i];
      end
    end
  end

  // ---------------- assertions ----------------
  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_idx_r <= res_cnt_r)
    else $error("result index past result count");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    move && res_cnt_nxt != 2'd0 |=> out_tvalid && res_idx_r == 2'd0)
    else $error("loaded results not presented");

  a_close_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_CLOSE |-> out_tlast && out_tdata == 8'd0)
    else $error("job close not the final result");

  a_idle_only_open: assert property (@(posedge clk) disable iff (!rst_n)
    !job_r |-> idle_r == 17'd0)
    else $error("idle count running with no job open");

  a_close_clears_job: assert property (@(posedge clk) disable iff (!rst_n)
    take && out_tuser == KIND_CLOSE |-> !job_r || in_vld_r)
    else $error("job still open after close result");

endmodule

>>> test/tb_top.sv
// Self-checking testbench for parallel_printer_port: drives bus accesses and ticks,
// predicts printed bytes, reads and job closes, and checks every result item.
// Depends on ppp_pkg and the parallel_printer_port RTL only.
module tb_top;
  import ppp_pkg::*;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] value;
    logic       last;
  } port_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;    // [7:0] write_value
  logic [2:0]  in_tuser = 3'd0;     // [2:0] cmd
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;           // [7:0] value
  logic [1:0]  out_tuser;           // [1:0] kind
  logic        out_tlast;
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [3:0]  cfg_paddr = 4'h0;
  logic [31:0] cfg_pwdata = 32'h0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  parallel_printer_port DUT (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Printer state as the port should hold it
  logic        lf_insert_on = 1'b0;
  logic        ff_on_close = 1'b0;
  logic [15:0] close_after = TIMEOUT_RST;
  logic [7:0]  latched_byte = 8'h00;
  logic [3:0]  ctrl_lines = 4'h0;
  logic        ack_flag = 1'b0;
  logic [7:0]  last_printed = 8'h00;
  logic        job_active = 1'b0;
  logic [16:0] idle_ticks = 17'd0;

  port_result_t step_out [0:RES_DEPTH-1];
  int           step_cnt;
  port_result_t pending_results [$];

  int err_count = 0;
  int items_sent = 0;
  int results_seen = 0;
  int jobs_closed = 0;
  int reg_writes = 0;
  int burst_left = 0;
  bit steady = 1'b0;

  function automatic void note(input kind_t k, input logic [7:0] v);
    step_out[step_cnt] = '{kind: k, value: v, last: 1'b0};
    step_cnt++;
  endfunction

  function automatic void print_char(input logic [7:0] b);
    job_active = 1'b1;
    idle_ticks = '0;
    note(KIND_PRINT, b);
    if (lf_insert_on) begin
      if (last_printed == CHAR_CR && b != CHAR_LF) note(KIND_PRINT, CHAR_LF);
      last_printed = b;
    end
  endfunction

  // Updates the printer state for one accepted item and queues what it emits
  function automatic void port_response(input cmd_t c, input logic [7:0] v);
    step_cnt = 0;
    case (c)
      CMD_RD_DATA: note(KIND_READ, latched_byte);
      CMD_RD_CTRL: note(KIND_READ, {4'h0, ctrl_lines});
      CMD_RD_STAT: begin
        note(KIND_READ, ack_flag ? STATUS_BASE : (STATUS_BASE | STATUS_NOACK));
        ack_flag = 1'b0;
      end
      CMD_WR_DATA: latched_byte = v;
      CMD_WR_CTRL: begin
        // falling strobe prints the latched byte
        if (!v[CTRL_STROBE] && ctrl_lines[CTRL_STROBE]) begin
          print_char(latched_byte);
          if (v[CTRL_AUTOLF] && latched_byte == CHAR_CR) print_char(CHAR_LF);
          ack_flag = 1'b1;
        end
        ctrl_lines = v[3:0] & CTRL_MASK;
      end
      CMD_TICK: begin
        if (job_active) begin
          if (idle_ticks != IDLE_MAX) idle_ticks++;
          if (close_after != 0 && idle_ticks > {1'b0, close_after}) begin
            if (ff_on_close) note(KIND_PRINT, CHAR_FF);
            note(KIND_CLOSE, 8'h00);
            last_printed = 8'h00;
            job_active = 1'b0;
            idle_ticks = '0;
          end
        end
      end
      default: ;
    endcase
    for (int i = 0; i < step_cnt; i++) begin
      step_out[i].last = (i == step_cnt - 1);
      pending_results.push_back(step_out[i]);
    end
  endfunction

  task automatic send(input cmd_t c, input logic [7:0] v);
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= v;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    port_response(c, v);
    items_sent++;
    if (!steady && burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 6) == 0) ? 40 : $urandom_range(0, 12);
    end else if (burst_left != 0) begin
      burst_left--;
    end
  endtask

  // Latch a byte, raise strobe, drop strobe with the requested autofeed line
  task automatic print_seq(input logic [7:0] b, input logic autofeed);
    logic [7:0] hi_ctrl;
    logic [7:0] lo_ctrl;
    hi_ctrl = 8'($urandom_range(0, 255));
    lo_ctrl = 8'($urandom_range(0, 255));
    hi_ctrl[CTRL_STROBE] = 1'b1;
    lo_ctrl[CTRL_STROBE] = 1'b0;
    lo_ctrl[CTRL_AUTOLF] = autofeed;
    send(CMD_WR_DATA, b);
    send(CMD_WR_CTRL, hi_ctrl);
    send(CMD_WR_CTRL, lo_ctrl);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return CHAR_CR;
    if (r < 6) return CHAR_LF;
    return 8'($urandom_range(0, 255));
  endfunction

  // Stop offering items and wait until every queued result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input reg_idx_t r, input logic [15:0] val);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {r, 2'b00};
    cfg_pwdata <= {16'h0, val};
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    // straight into a read-back of the same register
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (cfg_prdata !== {16'h0, val}) begin
      $error("reg %s: expected %0d, got %0d", r.name(), val, cfg_prdata);
      err_count++;
    end
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (r)
      REG_ADD_LF:  lf_insert_on = val[0];
      REG_ADD_FF:  ff_on_close = val[0];
      REG_TIMEOUT: close_after = val;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic lf, input logic ff, input logic [15:0] tmo);
    write_reg(REG_ADD_LF, {15'h0, lf});
    write_reg(REG_ADD_FF, {15'h0, ff});
    write_reg(REG_TIMEOUT, tmo);
  endtask

  // Receiver: stall pattern redrawn at random from four modes; a long hold on request
  int unsigned rx_cyc = 0;
  int          rx_mode = 0;
  int          hold_cnt = 0;
  logic [3:0]  hold_seq = 4'd0;
  logic [3:0]  hold_seen = 4'd0;

  always @(posedge clk) begin
    rx_cyc <= rx_cyc + 1;
    if (rx_cyc % 50 == 0) rx_mode <= $urandom_range(0, 3);
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
      out_tready <= 1'b0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_cnt <= 300;
      out_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        2: out_tready <= ($urandom_range(0, 9) < 3);
        default: out_tready <= (rx_cyc % 4 != 3);
      endcase
    end
  end

  always @(posedge clk) begin
    port_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result item: kind %0d value 0x%02h", out_tuser, out_tdata);
        err_count++;
      end else begin
        want = pending_results.pop_front();
        results_seen++;
        if (out_tuser !== want.kind) begin
          $error("kind: expected %0d, got %0d", want.kind, out_tuser);
          err_count++;
        end
        if (out_tdata !== want.value) begin
          $error("value: expected 0x%02h, got 0x%02h", want.value, out_tdata);
          err_count++;
        end
        if (out_tlast !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, out_tlast);
          err_count++;
        end
        if (want.kind == KIND_CLOSE) jobs_closed++;
      end
    end
  end

  task automatic test_reset_reads();
    send(CMD_RD_DATA, 8'hFF);
    send(CMD_RD_CTRL, 8'h00);
    send(CMD_RD_STAT, 8'hAA);
  endtask

  task automatic test_bus_access();
    send(CMD_WR_DATA, 8'hFF);
    send(CMD_RD_DATA, 8'h00);
    send(CMD_WR_CTRL, 8'hFF);   // strobe rises, nothing printed
    send(CMD_RD_CTRL, 8'h55);
    send(CMD_RSVD6, 8'hFF);
    send(CMD_RSVD7, 8'h00);
    send(CMD_WR_DATA, 8'h00);
    send(CMD_WR_CTRL, 8'h00);   // falling strobe prints 0x00
    send(CMD_RD_STAT, 8'h00);   // ack pending
    send(CMD_RD_STAT, 8'h00);   // ack cleared
  endtask

  task automatic test_line_feeds();
    drain();
    set_config(1'b1, 1'b0, TIMEOUT_RST);
    print_seq(CHAR_CR, 1'b1);   // CR then autofeed LF
    print_seq(CHAR_CR, 1'b0);
    print_seq(CHAR_CR, 1'b1);   // CR after CR with both options: three bytes
    print_seq(CHAR_CR, 1'b0);
    print_seq(8'h41, 1'b0);     // non-LF after CR gets an LF
  endtask

  task automatic test_job_close();
    drain();
    set_config(1'b0, 1'b1, 16'd1);
    send(CMD_TICK, 8'h00);
    send(CMD_TICK, 8'hFF);      // form feed and close
    send(CMD_TICK, 8'h00);      // no job open
    drain();
    write_reg(REG_ADD_FF, 16'd0);
    print_seq(8'h7E, 1'b1);
    send(CMD_TICK, 8'h00);
    send(CMD_TICK, 8'h00);      // close without form feed
  endtask

  task automatic test_random_mix();
    int start;
    int r;
    int run;
    logic [2:0] c;
    for (int p = 0; p < 6; p++) begin
      drain();
      case (p)
        0: set_config(1'b0, 1'b0, 16'd0);
        1: set_config(1'b1, 1'b1, 16'd1);
        2: set_config(1'b1, 1'b0, 16'hFFFF);
        3: set_config(1'b0, 1'b1, 16'd3);
        4: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      16'($urandom_range(2, 12)));
        default: set_config(1'b1, 1'b1, 16'($urandom_range(1, 6)));
      endcase
      start = items_sent;
      while (items_sent - start < 40) begin
        r = $urandom_range(0, 99);
        if (r < 50) begin
          print_seq(pick_char(), 1'($urandom_range(0, 1)));
        end else if (r < 70) begin
          run = (close_after != 0 && close_after < 16) ?
                $urandom_range(1, close_after + 2) : $urandom_range(1, 4);
          repeat (run) send(CMD_TICK, 8'($urandom_range(0, 255)));
        end else if (r < 85) begin
          c = 3'($urandom_range(0, 2));
          send(cmd_t'(c), 8'($urandom_range(0, 255)));
        end else begin
          c = 3'($urandom_range(0, 7));
          send(cmd_t'(c), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  // Receiver holds off while the sender keeps pushing multi-byte prints
  task automatic test_backpressure();
    drain();
    set_config(1'b1, 1'b1, 16'd4);
    hold_seq <= hold_seq + 4'd1;
    repeat (8) print_seq(pick_char(), 1'b1);
    repeat (6) send(CMD_TICK, 8'h00);
  endtask

  // A timeout written while a job is open applies to that job at once
  task automatic test_timeout_change();
    drain();
    set_config(1'b0, 1'b0, 16'd0);
    print_seq(8'h33, 1'b0);
    steady = 1'b1;
    repeat (10) send(CMD_TICK, 8'h00);
    steady = 1'b0;
    drain();
    write_reg(REG_TIMEOUT, 16'd4);
    send(CMD_TICK, 8'h00);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_reads();
    test_bus_access();
    test_line_feeds();
    test_job_close();
    test_random_mix();
    test_backpressure();
    test_timeout_change();
    drain();
    $display("Covered %0d items with %0d result items checked, %0d job closes,",
             items_sent, results_seen, jobs_closed);
    $display("%0d register writes, a long receiver stall and a timeout change mid-job.",
             reg_writes);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("PASS parallel_printer_port");
    end else begin
      $display("FAIL parallel_printer_port");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL parallel_printer_port");
    $finish;
  end

endmodule
